@@ hdl/rzs_pkg.sv @@
// Package: shared constants, widths and types for the rolling z-score signal block.
package rzs_pkg;

   localparam int HISTORY_DEPTH_DEF = 100;
   localparam int SYMBOL_COUNT_DEF  = 3;

   localparam int SYM_W    = 2;
   localparam int PRICE_W  = 32;
   localparam int MID_W    = 33;
   localparam int LEN_W    = 7;
   localparam int THR_W    = 16;
   localparam int SIG_W    = 2;
   localparam int SUM_W    = MID_W + LEN_W;
   localparam int SQ_W     = 2 * MID_W + LEN_W;
   localparam int VAR_W    = SQ_W + LEN_W;
   localparam int THR2_W   = 2 * THR_W;
   localparam int ZFRAC2_W = 24;
   localparam int LHS_W    = 2 * SUM_W + ZFRAC2_W;
   localparam int RHS_W    = VAR_W + THR2_W;

   localparam int MUL_A_W  = VAR_W;
   localparam int DIGIT_W  = 16;
   localparam int MUL_B_W  = 48;
   localparam int NDIG     = MUL_B_W / DIGIT_W;
   localparam int PROD_W   = MUL_A_W + MUL_B_W;

   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [1:0] REG_LOOKBACK = 2'd0;
   localparam logic [1:0] REG_THRESH   = 2'd1;
   localparam logic [1:0] REG_RUNNING  = 2'd2;

   localparam logic [LEN_W-1:0] LOOKBACK_RST = 7'd20;
   localparam logic [THR_W-1:0] THRESH_RST   = 16'd8192;

   localparam logic [SIG_W-1:0] SIG_NONE = 2'd0;
   localparam logic [SIG_W-1:0] SIG_BUY  = 2'd1;
   localparam logic [SIG_W-1:0] SIG_SELL = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STORE,
      ST_READ,
      ST_MUL,
      ST_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      OP_SQ,
      OP_NQ,
      OP_SS,
      OP_NC,
      OP_DD,
      OP_TT,
      OP_TV
   } op_type;

endpackage

@@ hdl/rolling_zscore_signal.sv @@
// Top level: rolling z-score signal, sequencer around a shared multiplier and history memory.
//
//   channel  dir  handshake               payload
//   req      in   req_valid / req_ready   req_symbol_index, req_best_bid, req_best_ask
//   rsp      out  rsp_valid / rsp_ready   rsp_signal
//   csr      in   APB psel/penable/pready paddr, pwdata, prdata
//
// A transaction that stores a sample walks the window of lookback_len samples:
// each sample in the window costs a memory read and a pass of the shared multiplier,
// then six more passes follow; zero deviation or zero offset ends it after the third of them.
// Stopped and invalid-symbol transactions skip the store; short-history ones answer after it.
// One transaction at a time; req_ready is low until the result is taken.
// Reset clears per-symbol counts and slots; the history memory needs no clearing.
module rolling_zscore_signal #(
   parameter int HISTORY_DEPTH = rzs_pkg::HISTORY_DEPTH_DEF,
   parameter int SYMBOL_COUNT  = rzs_pkg::SYMBOL_COUNT_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rzs_pkg::SYM_W-1:0]   req_symbol_index,
   input  logic [rzs_pkg::PRICE_W-1:0] req_best_bid,
   input  logic [rzs_pkg::PRICE_W-1:0] req_best_ask,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rzs_pkg::SIG_W-1:0]   rsp_signal,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [rzs_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [rzs_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [rzs_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import rzs_pkg::*;

   localparam int POS_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int SIDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
   localparam int ADDR_W = $clog2(HISTORY_DEPTH * SYMBOL_COUNT);

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   logic [LEN_W-1:0]  lookback_ff;
   logic [THR_W-1:0]  thresh_ff;
   logic              running_ff;

   logic [CNT_W-1:0]  cnt_ff [SYMBOL_COUNT];
   logic [POS_W-1:0]  slot_ff [SYMBOL_COUNT];

   logic [SYM_W-1:0]  sym_ff;
   logic [MID_W-1:0]  cur_ff, cur_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [LEN_W-1:0]  k_ff, k_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [VAR_W-1:0]  v_ff, v_in;
   logic [SUM_W-1:0]  dmag_ff, dmag_in;
   logic              pos_dev_ff, pos_dev_in;
   logic [LHS_W-1:0]  lhs_ff, lhs_in;
   logic [THR2_W-1:0] t2_ff, t2_in;
   logic [SIG_W-1:0]  sig_ff, sig_in;

   logic [SIDX_W-1:0] sidx;
   logic [CNT_W-1:0]  cnt_cur, cnt_next;
   logic [POS_W-1:0]  slot_cur, slot_next;
   logic              req_acc, sym_ok, store_en;
   logic              csr_wr;
   logic [ADDR_W-1:0] base_addr, mem_addr;
   logic [MID_W-1:0]  rd_data;
   logic              rd_en;
   logic              mul_start, mul_done;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;
   logic [SUM_W-1:0]   ncur;

   assign req_acc  = req_valid && req_ready;
   assign sym_ok   = 32'(req_symbol_index) < 32'(SYMBOL_COUNT);
   assign sidx     = SIDX_W'(sym_ff);
   assign cnt_cur  = cnt_ff[sidx];
   assign slot_cur = slot_ff[sidx];
   assign cnt_next = (32'(cnt_cur) < 32'(HISTORY_DEPTH)) ? cnt_cur + 1'b1 : cnt_cur;
   assign slot_next = (32'(slot_cur) == 32'(HISTORY_DEPTH - 1)) ? '0 : slot_cur + 1'b1;
   assign store_en  = (state_ff == ST_STORE);
   assign base_addr = ADDR_W'(32'(sidx) * HISTORY_DEPTH);
   assign mem_addr  = base_addr + ADDR_W'(store_en ? slot_cur : pos_ff);
   assign rd_en     = (state_ff == ST_READ);
   assign ncur      = prod[SUM_W-1:0];

   // configuration
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_LOOKBACK: csr_prdata = CSR_DW'(lookback_ff);
         REG_THRESH:   csr_prdata = CSR_DW'(thresh_ff);
         REG_RUNNING:  csr_prdata = CSR_DW'(running_ff);
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lookback_ff <= LOOKBACK_RST;
         thresh_ff   <= THRESH_RST;
         running_ff  <= 1'b0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_LOOKBACK: lookback_ff <= csr_pwdata[LEN_W-1:0];
            REG_THRESH:   thresh_ff   <= csr_pwdata[THR_W-1:0];
            REG_RUNNING:  running_ff  <= csr_pwdata[0];
            default:      ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = (running_ff && sym_ok) ? ST_STORE : ST_OUT;
            end
         end
         ST_STORE: begin
            if (lookback_ff == '0 || 32'(cnt_next) < 32'(lookback_ff)) begin
               state_in = ST_OUT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: state_in = ST_MUL;
         ST_MUL:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (mul_done) begin
               unique case (op_ff)
                  OP_SQ: state_in = (k_ff + 1'b1 == lookback_ff) ? ST_MUL : ST_READ;
                  OP_NC: state_in = (v_ff == '0 || ncur == sum_ff) ? ST_OUT : ST_MUL;
                  OP_TV: state_in = ST_OUT;
                  default: state_in = ST_MUL;
               endcase
            end
         end
         ST_OUT: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_OUT);
      mul_start = (state_ff == ST_MUL);
      unique case (op_ff)
         OP_SQ: begin
            mul_a = MUL_A_W'(rd_data);
            mul_b = MUL_B_W'(rd_data);
         end
         OP_NQ: begin
            mul_a = MUL_A_W'(sq_ff);
            mul_b = MUL_B_W'(lookback_ff);
         end
         OP_SS: begin
            mul_a = MUL_A_W'(sum_ff);
            mul_b = MUL_B_W'(sum_ff);
         end
         OP_NC: begin
            mul_a = MUL_A_W'(cur_ff);
            mul_b = MUL_B_W'(lookback_ff);
         end
         OP_DD: begin
            mul_a = MUL_A_W'(dmag_ff);
            mul_b = MUL_B_W'(dmag_ff);
         end
         OP_TT: begin
            mul_a = MUL_A_W'(thresh_ff);
            mul_b = MUL_B_W'(thresh_ff);
         end
         OP_TV: begin
            mul_a = v_ff;
            mul_b = MUL_B_W'(t2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      op_in      = op_ff;
      cur_in     = cur_ff;
      pos_in     = pos_ff;
      k_in       = k_ff;
      sum_in     = sum_ff;
      sq_in      = sq_ff;
      v_in       = v_ff;
      dmag_in    = dmag_ff;
      pos_dev_in = pos_dev_ff;
      lhs_in     = lhs_ff;
      t2_in      = t2_ff;
      sig_in     = sig_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cur_in = MID_W'(req_best_bid) + MID_W'(req_best_ask);
            sig_in = SIG_NONE;
         end
         ST_STORE: begin
            pos_in = slot_cur;
            k_in   = '0;
            sum_in = '0;
            sq_in  = '0;
            op_in  = OP_SQ;
         end
         ST_WAIT: begin
            if (mul_done) begin
               unique case (op_ff)
                  OP_SQ: begin
                     sq_in  = sq_ff + prod[SQ_W-1:0];
                     sum_in = sum_ff + SUM_W'(rd_data);
                     k_in   = k_ff + 1'b1;
                     pos_in = (pos_ff == '0) ? POS_W'(HISTORY_DEPTH - 1) : pos_ff - 1'b1;
                     if (k_ff + 1'b1 == lookback_ff) begin
                        op_in = OP_NQ;
                     end
                  end
                  OP_NQ: begin
                     v_in  = prod[VAR_W-1:0];
                     op_in = OP_SS;
                  end
                  OP_SS: begin
                     v_in  = v_ff - prod[VAR_W-1:0];
                     op_in = OP_NC;
                  end
                  OP_NC: begin
                     pos_dev_in = ncur > sum_ff;
                     dmag_in    = (ncur > sum_ff) ? ncur - sum_ff : sum_ff - ncur;
                     op_in      = OP_DD;
                  end
                  OP_DD: begin
                     lhs_in = {prod[2*SUM_W-1:0], {ZFRAC2_W{1'b0}}};
                     op_in  = OP_TT;
                  end
                  OP_TT: begin
                     t2_in = prod[THR2_W-1:0];
                     op_in = OP_TV;
                  end
                  OP_TV: begin
                     if (RHS_W'(lhs_ff) > prod[RHS_W-1:0]) begin
                        sig_in = pos_dev_ff ? SIG_SELL : SIG_BUY;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_SQ;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         sym_ff <= req_symbol_index;
      end
      cur_ff     <= cur_in;
      pos_ff     <= pos_in;
      k_ff       <= k_in;
      sum_ff     <= sum_in;
      sq_ff      <= sq_in;
      v_ff       <= v_in;
      dmag_ff    <= dmag_in;
      pos_dev_ff <= pos_dev_in;
      lhs_ff     <= lhs_in;
      t2_ff      <= t2_in;
      sig_ff     <= sig_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SYMBOL_COUNT; i++) begin
            cnt_ff[i]  <= '0;
            slot_ff[i] <= '0;
         end
      end else if (store_en) begin
         cnt_ff[sidx]  <= cnt_next;
         slot_ff[sidx] <= slot_next;
      end
   end

   assign rsp_signal = sig_ff;

   rzs_hist #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SYMBOL_COUNT  (SYMBOL_COUNT),
      .ADDR_W        (ADDR_W)
   ) u_hist (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (mem_addr),
      .wr_data (cur_ff),
      .rd_en   (rd_en),
      .rd_addr (mem_addr),
      .rd_data (rd_data)
   );

   rzs_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .done    (mul_done),
      .product (prod)
   );

endmodule

@@ hdl/rzs_hist.sv @@
// Sample history memory: one ring per symbol, flat array, registered read.
module rzs_hist #(
   parameter int HISTORY_DEPTH = rzs_pkg::HISTORY_DEPTH_DEF,
   parameter int SYMBOL_COUNT  = rzs_pkg::SYMBOL_COUNT_DEF,
   parameter int ADDR_W        = $clog2(HISTORY_DEPTH * SYMBOL_COUNT)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [rzs_pkg::MID_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [rzs_pkg::MID_W-1:0] rd_data
);
   import rzs_pkg::*;

   localparam int ENTRIES = HISTORY_DEPTH * SYMBOL_COUNT;

   logic [MID_W-1:0] mem [ENTRIES];
   logic [MID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/rzs_mul.sv @@
// Shared multiplier: wide operand times a 48-bit operand, one 16-bit digit per cycle.
module rzs_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [rzs_pkg::MUL_A_W-1:0] op_a,
   input  logic [rzs_pkg::MUL_B_W-1:0] op_b,
   output logic                        done,
   output logic [rzs_pkg::PROD_W-1:0]  product
);
   import rzs_pkg::*;

   localparam int DIG_CW = $clog2(NDIG);

   logic [MUL_A_W-1:0] a_ff;
   logic [MUL_B_W-1:0] b_ff;
   logic [PROD_W-1:0]  acc_ff, acc_in;
   logic [DIG_CW-1:0]  dig_ff, dig_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [MUL_A_W+DIGIT_W-1:0] part;

   always_comb begin
      part    = a_ff * b_ff[DIGIT_W*dig_ff +: DIGIT_W];
      acc_in  = acc_ff;
      dig_in  = dig_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in  = '0;
         dig_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + (PROD_W'(part) << (DIGIT_W * dig_ff));
         dig_in = dig_ff + 1'b1;
         if (dig_ff == DIG_CW'(NDIG - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         b_ff <= op_b;
      end
      acc_ff <= acc_in;
      dig_ff <= dig_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ hdl/rzs_checker.sv @@
// Port-level checker for the rolling z-score signal block, with its bind.
module rzs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [rzs_pkg::SIG_W-1:0] rsp_signal
);
   import rzs_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_signal))
      else $error("result changed while stalled");

   a_sig_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_signal == SIG_NONE || rsp_signal == SIG_BUY
                     || rsp_signal == SIG_SELL))
      else $error("bad signal code");

   a_one_at_time: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("ready while a result is pending");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready right after a transaction");

   a_rsp_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> !rsp_valid)
      else $error("result repeated");

endmodule

bind rolling_zscore_signal rzs_checker u_rzs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_signal (rsp_signal)
);

@@ bench/tb_top.sv @@
// Testbench for rolling_zscore_signal: directed table, random bursts, predictor check.
`timescale 1ns / 1ps

module tb_top;
   import rzs_pkg::*;

   localparam int DEPTH = 100;
   localparam int NSYM  = 3;
   localparam int NO_TYPED = -1;

   typedef struct {
      bit               cfg;
      logic [1:0]       reg_idx;
      logic [31:0]      value;
      logic [SYM_W-1:0] sym;
      logic [31:0]      bid;
      logic [31:0]      ask;
      int               want;
   } stim_row_type;

   typedef struct {
      int lookback;
      int thresh;
      int run;
      int items;
   } phase_cfg_type;

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_ready;
   logic [SYM_W-1:0]    req_symbol_index = '0;
   logic [PRICE_W-1:0]  req_best_bid = '0;
   logic [PRICE_W-1:0]  req_best_ask = '0;
   int                  req_want = NO_TYPED;
   logic                rsp_valid;
   logic                rsp_ready = 0;
   logic [SIG_W-1:0]    rsp_signal;
   logic                csr_psel = 0;
   logic                csr_penable = 0;
   logic                csr_pwrite = 0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   rolling_zscore_signal dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [MID_W-1:0]    mid_ring [NSYM][DEPTH];
   int                  held [NSYM];
   int                  next_slot [NSYM];
   int                  window_len = LOOKBACK_RST;
   int                  z_thr = THRESH_RST;
   bit                  is_running = 0;

   logic [SIG_W-1:0]    pending_signals [$];
   int                  errors = 0;
   int                  sent = 0;
   int                  buys = 0;
   int                  sells = 0;

   function automatic logic [SIG_W-1:0] zscore_signal(logic [SYM_W-1:0] sym,
                                                       logic [31:0] bid, logic [31:0] ask);
      logic [MID_W-1:0] cur;
      logic [127:0]     s, q, x, v, ncur, dmag, lhs, rhs, thr;
      int               slt, p, n;
      if (!is_running || sym >= NSYM) return SIG_NONE;
      cur = {1'b0, bid} + {1'b0, ask};
      slt = next_slot[sym];
      mid_ring[sym][slt] = cur;
      next_slot[sym] = (slt + 1) % DEPTH;
      if (held[sym] < DEPTH) held[sym]++;
      n = window_len;
      if (n == 0 || held[sym] < n) return SIG_NONE;
      s = 0;
      q = 0;
      p = slt;
      for (int k = 0; k < n; k++) begin
         x = mid_ring[sym][p];
         s += x;
         q += x * x;
         p = (p == 0) ? DEPTH - 1 : p - 1;
      end
      v = n * q - s * s;
      if (v == 0) return SIG_NONE;
      ncur = n * cur;
      if (ncur == s) return SIG_NONE;
      dmag = (ncur > s) ? ncur - s : s - ncur;
      lhs = (dmag * dmag) << 24;
      thr = z_thr;
      rhs = thr * thr * v;
      if (lhs > rhs) return (ncur > s) ? SIG_SELL : SIG_BUY;
      return SIG_NONE;
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            logic [SIG_W-1:0] sig;
            sig = zscore_signal(req_symbol_index, req_best_bid, req_best_ask);
            if (req_want != NO_TYPED) sig = req_want[SIG_W-1:0];
            pending_signals.insert(pending_signals.size(), sig);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_signals.size() == 0) begin
               $error("unexpected transaction: signal %0d", rsp_signal);
               errors++;
            end else begin
               logic [SIG_W-1:0] exp_sig;
               exp_sig = pending_signals.pop_front();
               if (rsp_signal !== exp_sig) begin
                  $error("signal: expected %0d, got %0d", exp_sig, rsp_signal);
                  errors++;
               end
               if (exp_sig == SIG_BUY) buys++;
               if (exp_sig == SIG_SELL) sells++;
            end
         end
      end
   end

   // receiver: ready rate changes during the run
   int ready_pct = 100;
   int rcycle = 0;
   always @(posedge clock) begin
      rcycle <= rcycle + 1;
      if (rcycle % 400 == 0) ready_pct <= (rcycle % 1200 == 0) ? 100 : $urandom_range(20, 90);
      rsp_ready <= ($urandom_range(0, 99) < ready_pct);
   end

   task automatic send(logic [SYM_W-1:0] sym, logic [31:0] bid, logic [31:0] ask, int want);
      req_valid <= 1;
      req_symbol_index <= sym;
      req_best_bid <= bid;
      req_best_ask <= ask;
      req_want <= want;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic pause();
      int gap;
      gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 12) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_signals.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1;
      csr_penable <= 0;
      csr_pwrite <= 1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0;
      csr_penable <= 0;
      csr_pwrite <= 0;
      case (idx)
         REG_LOOKBACK: window_len = value[LEN_W-1:0];
         REG_THRESH:   z_thr = value[THR_W-1:0];
         REG_RUNNING:  is_running = value[0];
         default: ;
      endcase
   endtask

   function automatic stim_row_type item_row(logic [SYM_W-1:0] sym, logic [31:0] bid,
                                             logic [31:0] ask, int want);
      return '{0, 2'd0, 32'd0, sym, bid, ask, want};
   endfunction

   function automatic stim_row_type cfg_row(logic [1:0] idx, logic [31:0] value);
      return '{1, idx, value, '0, 32'd0, 32'd0, NO_TYPED};
   endfunction

   stim_row_type  directed [$];
   phase_cfg_type phases [$];
   logic [31:0] base [NSYM];

   function automatic void add_row(stim_row_type row);
      directed.insert(directed.size(), row);
   endfunction

   function automatic void add_phase(int lookback, int thresh, int run, int items);
      phase_cfg_type ph;
      ph = '{lookback, thresh, run, items};
      phases.insert(phases.size(), ph);
   endfunction

   initial begin
      for (int i = 0; i < NSYM; i++) begin
         held[i] = 0;
         next_slot[i] = 0;
      end
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // stopped after reset, invalid symbol, extremes, edge lookbacks
      add_row(item_row(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIG_NONE));
      add_row(item_row(2'd3, 32'd5, 32'd7, SIG_NONE));
      add_row(cfg_row(REG_RUNNING, 1));
      add_row(item_row(2'd3, 32'hFFFF_FFFF, 32'd0, SIG_NONE));
      add_row(item_row(2'd0, 32'd1, 32'd1, SIG_NONE));
      add_row(cfg_row(REG_LOOKBACK, 1));
      add_row(item_row(2'd0, 32'd0, 32'd0, SIG_NONE));
      add_row(item_row(2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, SIG_NONE));
      add_row(cfg_row(REG_LOOKBACK, 0));
      add_row(item_row(2'd1, 32'd100, 32'd102, SIG_NONE));
      add_row(cfg_row(REG_LOOKBACK, 127));
      add_row(item_row(2'd1, 32'd100, 32'd102, SIG_NONE));
      add_row(cfg_row(REG_LOOKBACK, 2));
      add_row(cfg_row(REG_THRESH, 0));
      add_row(item_row(2'd1, 32'd100, 32'd102, NO_TYPED));
      add_row(item_row(2'd2, 32'd10, 32'd10, NO_TYPED));
      add_row(item_row(2'd2, 32'd20, 32'd20, NO_TYPED));
      add_row(item_row(2'd2, 32'd5, 32'd5, NO_TYPED));
      add_row(cfg_row(REG_THRESH, 65535));
      add_row(cfg_row(REG_LOOKBACK, 3));
      add_row(item_row(2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NO_TYPED));
      add_row(item_row(2'd0, 32'd0, 32'hFFFF_FFFF, NO_TYPED));
      add_row(item_row(2'd2, 32'd0, 32'd0, NO_TYPED));

      foreach (directed[i]) begin
         if (directed[i].cfg) begin
            drain();
            csr_write(directed[i].reg_idx, directed[i].value);
         end else begin
            send(directed[i].sym, directed[i].bid, directed[i].ask, directed[i].want);
            pause();
         end
      end

      add_phase(20, 8192, 1, 300);
      add_phase(1, 100, 1, 100);
      add_phase(5, 4096, 1, 300);
      add_phase(100, 8192, 1, 120);
      add_phase(127, 8192, 1, 40);
      add_phase(0, 0, 1, 40);
      add_phase(10, 0, 1, 200);
      add_phase(50, 65535, 1, 150);
      add_phase(8, 12000, 0, 60);
      add_phase(30, 6000, 1, 300);
      add_phase(3, 2048, 1, 200);

      foreach (phases[ph]) begin
         drain();
         csr_write(REG_LOOKBACK, phases[ph].lookback);
         csr_write(REG_THRESH, phases[ph].thresh);
         csr_write(REG_RUNNING, phases[ph].run);
         for (int i = 0; i < NSYM; i++) base[i] = $urandom_range(0, 32'hFFFF_F000);
         for (int k = 0; k < phases[ph].items; k++) begin
            int          r;
            logic [1:0]  sym;
            logic [31:0] bid, ask;
            r = $urandom_range(0, 99);
            sym = 2'($urandom_range(0, NSYM - 1));
            if (r < 5) begin
               sym = 2'd3;
               bid = $urandom;
               ask = $urandom;
            end else if (r < 10) begin
               bid = $urandom;
               ask = $urandom;
            end else if (r < 18) begin
               bid = base[sym];
               ask = base[sym] + 2;
            end else begin
               bid = base[sym] + $urandom_range(0, 40);
               if (r > 90) bid = bid + $urandom_range(0, 800);
               else if (r > 85) bid = bid - $urandom_range(0, 800);
               ask = bid + $urandom_range(0, 6);
            end
            send(sym, bid, ask, NO_TYPED);
            if ($urandom_range(0, 3) == 0) pause();
         end
      end

      drain();
      $display("sent %0d transactions over %0d settings; buy %0d, sell %0d",
               sent, phases.size() + 1, buys, sells);
      if (errors == 0) $display("tb_top OK");
      else $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #100ms;
      $display("timeout");
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
